/* sv/ffba_pkg.sv */
`default_nettype none
package ffba_pkg;
    localparam int MAX_BLOCKS = 1024;
    localparam int HEADER_BYTES = 32;
    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = IDX_W + 1;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE = 2'd1;
    localparam logic [1:0] OP_REALLOC = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_SIZE = 2'd1;
    localparam logic [1:0] ST_SPACE = 2'd2;
    localparam logic [1:0] ST_NOBLOCK = 2'd3;

    localparam logic [0:0] CFG_MAX_REQUEST = 1'd0;
    localparam logic [0:0] CFG_HEAP_CAPACITY = 1'd1;

    localparam logic [26:0] MAX_REQUEST_RESET = 27'd100000000;
    localparam logic [31:0] HEAP_CAPACITY_RESET = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [26:0] request_size;
        logic [31:0] block_address;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] result_address;
        logic [10:0] free_blocks;
        logic [31:0] free_bytes;
        logic [10:0] allocated_blocks;
        logic [31:0] allocated_bytes;
        logic [31:0] metadata_bytes;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic             load;      // capture request
        logic             scan_clr;  // reset scan index
        logic             scan_inc;  // advance scan
        logic             rd;        // issue table read at scan index
        logic             take;      // mark found block used
        logic             append;    // append block at break
        logic             mark_old;  // mark old block free
        logic             result;    // emit result
        logic [1:0]       status;
        logic [1:0]       res_sel;   // 0 none, 1 grabbed, 2 old addr
    } cmd_t;

    localparam logic [1:0] RES_NONE = 2'd0;
    localparam logic [1:0] RES_GRAB = 2'd1;
    localparam logic [1:0] RES_OLD = 2'd2;

    // datapath -> controller
    typedef struct packed {
        logic       size_ok;
        logic       addr_zero;
        logic [1:0] opcode;
        logic       scan_done;  // scan index reached block count
        logic       hit_fit;    // read entry is free and large enough
        logic       hit_addr;   // read entry start equals address
        logic       old_free;   // found old block is already free
        logic       old_fits;   // found old block size >= request
        logic       can_grow;
    } stat_t;
endpackage
`default_nettype wire

/* sv/ffba_ram.sv */
`default_nettype none
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* sv/ffba_datapath.sv */
`default_nettype none
module ffba_datapath
    import ffba_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire req_t        req,
    input  wire cmd_t        cmd,
    output stat_t            stat,
    output rsp_t             rsp,
    output logic             rsp_valid
);
    logic [26:0] max_req_reg;
    logic [31:0] cap_reg;
    req_t        req_reg;
    logic [CNT_W-1:0] count_reg, free_cnt_reg;
    logic [31:0] free_bytes_reg, total_reg, brk_reg;
    logic [CNT_W-1:0] scan_reg;
    logic [IDX_W-1:0] rd_idx_reg;   // index of entry in rdata
    logic [IDX_W-1:0] old_idx_reg;
    logic [26:0] old_size_reg;
    logic [31:0] grab_reg;
    logic [26:0] size_q;
    logic [31:0] start_q;
    logic        free_q;
    logic [32:0] end_w;
    logic        we_size, we_mark;
    logic [IDX_W-1:0] waddr;
    logic        mark_val;
    logic [31:0] new_start;
    logic [CNT_W-1:0] fc_n, cnt_n;
    logic [31:0] fb_n, tot_n;

    assign end_w = {1'b0, brk_reg} + 33'(HEADER_BYTES) + 33'(req_reg.request_size);
    assign new_start = brk_reg + 32'(HEADER_BYTES);

    assign we_size = cmd.append;
    assign we_mark = cmd.append | cmd.take | cmd.mark_old;
    assign waddr = cmd.append ? count_reg[IDX_W-1:0]
                 : (cmd.take ? rd_idx_reg : old_idx_reg);
    assign mark_val = cmd.mark_old;

    ffba_ram #(.WIDTH(27), .DEPTH(MAX_BLOCKS)) u_size (
        .clk(clk), .we(we_size), .waddr(waddr), .wdata(req_reg.request_size),
        .raddr(scan_reg[IDX_W-1:0]), .rdata(size_q));
    ffba_ram #(.WIDTH(32), .DEPTH(MAX_BLOCKS)) u_start (
        .clk(clk), .we(we_size), .waddr(waddr), .wdata(new_start),
        .raddr(scan_reg[IDX_W-1:0]), .rdata(start_q));
    ffba_ram #(.WIDTH(1), .DEPTH(MAX_BLOCKS)) u_mark (
        .clk(clk), .we(we_mark), .waddr(waddr), .wdata(mark_val),
        .raddr(scan_reg[IDX_W-1:0]), .rdata(free_q));

    assign stat.size_ok = (req_reg.request_size != 27'd0)
                        && (req_reg.request_size <= max_req_reg);
    assign stat.addr_zero = (req_reg.block_address == 32'd0);
    assign stat.opcode = req_reg.opcode;
    assign stat.scan_done = (scan_reg >= count_reg);
    assign stat.hit_fit = free_q && (size_q >= req_reg.request_size);
    assign stat.hit_addr = (start_q == req_reg.block_address);
    assign stat.old_free = free_q;
    assign stat.old_fits = (size_q >= req_reg.request_size);
    assign stat.can_grow = (count_reg < CNT_W'(MAX_BLOCKS))
                         && (end_w <= {1'b0, cap_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_req_reg <= MAX_REQUEST_RESET;
            cap_reg <= HEAP_CAPACITY_RESET;
            count_reg <= '0;
            free_cnt_reg <= '0;
            free_bytes_reg <= '0;
            total_reg <= '0;
            brk_reg <= '0;
            rsp_valid <= 1'b0;
        end
        else
        begin
            rsp_valid <= cmd.result;
            if (cfg_we)
            begin
                if (cfg_index == CFG_MAX_REQUEST)
                begin
                    max_req_reg <= cfg_data[26:0];
                end
                else
                begin
                    cap_reg <= cfg_data;
                end
            end
            if (cmd.take)
            begin
                free_cnt_reg <= free_cnt_reg - 1'b1;
                free_bytes_reg <= free_bytes_reg - 32'(size_q);
            end
            if (cmd.append)
            begin
                count_reg <= count_reg + 1'b1;
                total_reg <= total_reg + 32'(req_reg.request_size);
                brk_reg <= end_w[31:0];
            end
            if (cmd.mark_old)
            begin
                free_cnt_reg <= free_cnt_reg + 1'b1;
                free_bytes_reg <= free_bytes_reg + 32'(old_size_reg);
            end
        end
    end

    // statistics follow the live counters, updated the same edge as result
    always_comb
    begin
        fc_n = free_cnt_reg;
        fb_n = free_bytes_reg;
        cnt_n = count_reg;
        tot_n = total_reg;
        if (cmd.take)
        begin
            fc_n = free_cnt_reg - 1'b1;
            fb_n = free_bytes_reg - 32'(size_q);
        end
        if (cmd.append)
        begin
            cnt_n = count_reg + 1'b1;
            tot_n = total_reg + 32'(req_reg.request_size);
        end
        if (cmd.mark_old)
        begin
            fc_n = free_cnt_reg + 1'b1;
            fb_n = free_bytes_reg + 32'(old_size_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (cmd.scan_clr)
        begin
            scan_reg <= '0;
        end
        else if (cmd.scan_inc)
        begin
            scan_reg <= scan_reg + 1'b1;
        end
        if (cmd.rd)
        begin
            rd_idx_reg <= scan_reg[IDX_W-1:0];
        end
        if (cmd.take)
        begin
            grab_reg <= start_q;
        end
        if (cmd.append)
        begin
            grab_reg <= new_start;
        end
        if (cmd.scan_clr)
        begin
            old_idx_reg <= rd_idx_reg;
            old_size_reg <= size_q;
        end
        if (cmd.result)
        begin
            rsp.status <= cmd.status;
            case (cmd.res_sel)
                RES_GRAB: rsp.result_address <= cmd.take ? start_q
                                              : (cmd.append ? new_start : grab_reg);
                RES_OLD:  rsp.result_address <= req_reg.block_address;
                default:  rsp.result_address <= 32'd0;
            endcase
            rsp.free_blocks <= 11'(fc_n);
            rsp.free_bytes <= fb_n;
            rsp.allocated_blocks <= 11'(cnt_n);
            rsp.allocated_bytes <= tot_n;
            rsp.metadata_bytes <= 32'(cnt_n) * 32'(HEADER_BYTES);
        end
    end
endmodule
`default_nettype wire

/* sv/ffba_ctrl.sv */
`default_nettype none
module ffba_ctrl
    import ffba_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    output logic       busy,
    input  wire stat_t stat,
    output cmd_t       cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_FIND = 3'd2;  // address lookup, issue reads
    localparam logic [2:0] S_FCHK = 3'd3;  // check looked-up entry
    localparam logic [2:0] S_GRAB = 3'd4;  // first-fit scan, issue reads
    localparam logic [2:0] S_GCHK = 3'd5;  // check scanned entry
    localparam logic [2:0] S_DONE = 3'd6;
    localparam logic [2:0] S_MARK = 3'd7;  // mark old block free, emit result

    logic [2:0] state_reg, state_next;
    logic       realloc_reg, realloc_next;  // grab then free old

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        realloc_next = realloc_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
                if (start)
                begin
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                cmd.scan_clr = 1'b1;
                realloc_next = 1'b0;
                if (stat.opcode == OP_ALLOC || stat.opcode == OP_REALLOC)
                begin
                    if (!stat.size_ok)
                    begin
                        cmd.result = 1'b1;
                        cmd.status = ST_SIZE;
                        state_next = S_DONE;
                    end
                    else if (stat.opcode == OP_ALLOC || stat.addr_zero)
                    begin
                        state_next = S_GRAB;
                    end
                    else
                    begin
                        state_next = S_FIND;
                    end
                end
                else if (stat.opcode == OP_FREE && !stat.addr_zero)
                begin
                    state_next = S_FIND;
                end
                else
                begin
                    cmd.result = 1'b1;
                    cmd.status = ST_OK;
                    state_next = S_DONE;
                end
            end
            S_FIND:
            begin
                if (stat.scan_done)
                begin
                    cmd.result = 1'b1;
                    cmd.status = ST_NOBLOCK;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd = 1'b1;
                    cmd.scan_inc = 1'b1;
                    state_next = S_FCHK;
                end
            end
            S_FCHK:
            begin
                if (!stat.hit_addr)
                begin
                    state_next = S_FIND;
                end
                else if (stat.opcode == OP_FREE)
                begin
                    cmd.scan_clr = 1'b1;   // latch old index and size
                    if (stat.old_free)
                    begin
                        cmd.result = 1'b1;
                        cmd.status = ST_OK;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_MARK;
                    end
                end
                else if (stat.old_fits)
                begin
                    cmd.result = 1'b1;
                    cmd.status = ST_OK;
                    cmd.res_sel = RES_OLD;
                    state_next = S_DONE;
                end
                else
                begin
                    // old block gets freed after the grab unless already free
                    cmd.scan_clr = 1'b1;
                    realloc_next = !stat.old_free;
                    state_next = S_GRAB;
                end
            end
            S_GRAB:
            begin
                if (stat.scan_done)
                begin
                    if (stat.can_grow)
                    begin
                        cmd.append = 1'b1;
                        if (realloc_reg)
                        begin
                            state_next = S_MARK;
                        end
                        else
                        begin
                            cmd.result = 1'b1;
                            cmd.status = ST_OK;
                            cmd.res_sel = RES_GRAB;
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        cmd.result = 1'b1;
                        cmd.status = ST_SPACE;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    cmd.rd = 1'b1;
                    cmd.scan_inc = 1'b1;
                    state_next = S_GCHK;
                end
            end
            S_GCHK:
            begin
                if (stat.hit_fit)
                begin
                    cmd.take = 1'b1;
                    if (realloc_reg)
                    begin
                        state_next = S_MARK;
                    end
                    else
                    begin
                        cmd.result = 1'b1;
                        cmd.status = ST_OK;
                        cmd.res_sel = RES_GRAB;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    state_next = S_GRAB;
                end
            end
            S_MARK:
            begin
                cmd.mark_old = 1'b1;
                cmd.result = 1'b1;
                cmd.status = ST_OK;
                cmd.res_sel = realloc_reg ? RES_GRAB : RES_NONE;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            realloc_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            realloc_reg <= realloc_next;
        end
    end
endmodule
`default_nettype wire

/* sv/first_fit_block_allocator.sv */
`default_nettype none
// First-fit block allocator over a grow-only heap.
// Request channel: an item (opcode, request_size, block_address) is taken
// at a rising edge with start high and busy low. busy stays high until the
// result has gone out.
// Result channel: result_valid is high for exactly one cycle with the
// result item (status, address, heap statistics). The receiver cannot
// stall; every result must be taken in that cycle.
// Config: cfg_we/cfg_index/cfg_data write max_request (0) or
// heap_capacity (1) at once; write only while busy is low.
// Flow: size-rejected, null-free and unknown-opcode items finish without
// a table walk. Lookups and first-fit scans walk the block table one entry
// at a time (registered RAM read then compare); a reallocate may do a
// lookup, a scan, then free the old block, and alloc or free does one walk.
// Reset: counters, break and config return to defaults; table contents
// need no clearing since only entries below the block count are read.
module first_fit_block_allocator
    import ffba_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire req_t        request,
    output logic             result_valid,
    output rsp_t             result,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    cmd_t  cmd;
    stat_t stat;

    ffba_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .stat(stat), .cmd(cmd));

    ffba_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .req(request), .cmd(cmd), .stat(stat),
        .rsp(result), .rsp_valid(result_valid));

`ifndef SYNTHESIS
    // a result is only produced while an item is in flight
    a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result without item");
    // results are never back to back
    a_one_res: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("double result");
    // failed requests never return an address
    a_fail_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status != ST_OK) |-> result.result_address == 32'd0)
        else $error("address on failure");
`endif
endmodule
`default_nettype wire

/* sim/testbench.sv */
`default_nettype none
// Testbench for first_fit_block_allocator.
// Items go in on the start/busy handshake; results come back one cycle
// each on result_valid and are checked field by field against a local
// model of the block table (first fit, grow-only break, free marks).
module testbench;
    import ffba_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASE_ITEMS = 95;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    req_t        request;
    logic        result_valid;
    rsp_t        result;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [31:0] cfg_data;

    first_fit_block_allocator u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .request     (request),
        .result_valid(result_valid),
        .result      (result),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ---------------- heap model ----------------
    logic [26:0] heap_max_request;
    logic [31:0] heap_capacity;
    logic [26:0] blk_size [MAX_BLOCKS];
    logic [31:0] blk_start [MAX_BLOCKS];
    logic        blk_free [MAX_BLOCKS];
    int unsigned blk_count;
    int unsigned free_cnt;
    logic [31:0] free_byte_sum;
    logic [31:0] total_byte_sum;
    logic [31:0] heap_break;

    rsp_t pending_results[$];
    int   error_count;
    int   idle_cycles;

    // First fit over free blocks, else append at the break. 0 = no room.
    task automatic take_block(input logic [26:0] size, output logic [31:0] addr);
        longint unsigned tail;
        addr = '0;
        for (int i = 0; i < blk_count; i++)
        begin
            if (blk_free[i] && blk_size[i] >= size)
            begin
                blk_free[i] = 1'b0;
                free_cnt--;
                free_byte_sum -= 32'(blk_size[i]);
                addr = blk_start[i];
                return;
            end
        end
        tail = longint'(heap_break) + HEADER_BYTES + longint'(size);
        if (blk_count >= MAX_BLOCKS || tail > longint'(heap_capacity))
            return;
        blk_start[blk_count] = heap_break + HEADER_BYTES;
        blk_size[blk_count] = size;
        blk_free[blk_count] = 1'b0;
        addr = blk_start[blk_count];
        blk_count++;
        total_byte_sum += 32'(size);
        heap_break = 32'(tail);
    endtask

    function automatic int find_block(logic [31:0] addr);
        for (int i = 0; i < blk_count; i++)
            if (blk_start[i] == addr)
                return i;
        return -1;
    endfunction

    task automatic release_block(input int idx);
        if (blk_free[idx])
            return;
        blk_free[idx] = 1'b1;
        free_cnt++;
        free_byte_sum += 32'(blk_size[idx]);
    endtask

    task automatic heap_apply(input req_t r, output rsp_t rsp);
        logic        size_good;
        logic [31:0] got;
        int          idx;
        size_good = r.request_size != 0 && r.request_size <= heap_max_request;
        rsp = '0;
        rsp.status = ST_OK;
        case (r.opcode)
            OP_ALLOC:
            begin
                if (!size_good)
                    rsp.status = ST_SIZE;
                else
                begin
                    take_block(r.request_size, got);
                    rsp.result_address = got;
                    if (got == 0)
                        rsp.status = ST_SPACE;
                end
            end
            OP_FREE:
            begin
                if (r.block_address != 0)
                begin
                    idx = find_block(r.block_address);
                    if (idx < 0)
                        rsp.status = ST_NOBLOCK;
                    else
                        release_block(idx);
                end
            end
            OP_REALLOC:
            begin
                if (!size_good)
                    rsp.status = ST_SIZE;
                else if (r.block_address == 0)
                begin
                    take_block(r.request_size, got);
                    rsp.result_address = got;
                    if (got == 0)
                        rsp.status = ST_SPACE;
                end
                else
                begin
                    idx = find_block(r.block_address);
                    if (idx < 0)
                        rsp.status = ST_NOBLOCK;
                    else if (blk_size[idx] >= r.request_size)
                        rsp.result_address = r.block_address;
                    else
                    begin
                        // old block stays put if the new one cannot be had
                        take_block(r.request_size, got);
                        rsp.result_address = got;
                        if (got == 0)
                            rsp.status = ST_SPACE;
                        else
                            release_block(idx);
                    end
                end
            end
            default: ;  // undefined opcode: no effect
        endcase
        rsp.free_blocks = 11'(free_cnt);
        rsp.free_bytes = free_byte_sum;
        rsp.allocated_blocks = 11'(blk_count);
        rsp.allocated_bytes = total_byte_sum;
        rsp.metadata_bytes = 32'(HEADER_BYTES * blk_count);
    endtask

    // ---------------- checking ----------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && result_valid)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with nothing pending", 32'd1, 32'd0);
            else
            begin
                want = pending_results.pop_front();
                if (result.status !== want.status)
                    report_mismatch("status", 32'(result.status), 32'(want.status));
                if (result.result_address !== want.result_address)
                    report_mismatch("result_address", result.result_address,
                                    want.result_address);
                if (result.free_blocks !== want.free_blocks)
                    report_mismatch("free_blocks", 32'(result.free_blocks),
                                    32'(want.free_blocks));
                if (result.free_bytes !== want.free_bytes)
                    report_mismatch("free_bytes", result.free_bytes, want.free_bytes);
                if (result.allocated_blocks !== want.allocated_blocks)
                    report_mismatch("allocated_blocks", 32'(result.allocated_blocks),
                                    32'(want.allocated_blocks));
                if (result.allocated_bytes !== want.allocated_bytes)
                    report_mismatch("allocated_bytes", result.allocated_bytes,
                                    want.allocated_bytes);
                if (result.metadata_bytes !== want.metadata_bytes)
                    report_mismatch("metadata_bytes", result.metadata_bytes,
                                    want.metadata_bytes);
            end
        end
    end

    // Watchdog: cycles in which no item and no result moved.
    always @(posedge clk)
    begin
        if (!rst_n || result_valid || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("first_fit_block_allocator verification failed");
            $finish;
        end
    end

    // ---------------- driving ----------------
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Called at a falling edge; returns at a falling edge with start still high.
    // Typed expectations override status/address; stats always from the model.
    task automatic send_item(input req_t r, input bit typed = 0,
                             input logic [1:0] want_st = ST_OK,
                             input logic [31:0] want_addr = '0);
        int   gap;
        rsp_t rsp;
        gap = gap_len();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        request <= r;
        // busy is stable between edges; the next rising edge with busy low accepts
        while (busy)
            @(negedge clk);
        @(posedge clk);
        heap_apply(r, rsp);
        if (typed)
        begin
            rsp.status = want_st;
            rsp.result_address = want_addr;
        end
        pending_results.push_back(rsp);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_results.size() != 0 || busy)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_MAX_REQUEST)
            heap_max_request = value[26:0];
        else
            heap_capacity = value;
    endtask

    function automatic req_t random_item();
        req_t r;
        int   roll;
        r.opcode = OP_ALLOC;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            r.opcode = OP_ALLOC;
        else if (roll < 72)
            r.opcode = OP_FREE;
        else if (roll < 97)
            r.opcode = OP_REALLOC;
        else
            r.opcode = 2'd3;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            r.request_size = 27'($urandom_range(1, 256));
        else if (roll < 85)
            r.request_size = 27'($urandom_range(0, 4096));
        else if (roll < 93)
            r.request_size = 27'd0;
        else if (roll < 98)
            r.request_size = heap_max_request + 27'($urandom_range(0, 3)) - 27'd1;
        else
            r.request_size = 27'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 70 && blk_count > 0)
            r.block_address = blk_start[$urandom_range(0, blk_count - 1)];
        else if (roll < 82)
            r.block_address = '0;
        else if (roll < 90 && blk_count > 0)
            r.block_address = blk_start[$urandom_range(0, blk_count - 1)] + 1;
        else
            r.block_address = $urandom;
        return r;
    endfunction

    // directed rows: op, size, address, typed, status, address
    typedef struct {
        logic [1:0]  op;
        logic [26:0] size;
        logic [31:0] addr;
        bit          typed;
        logic [1:0]  st;
        logic [31:0] res;
    } dir_row_t;

    dir_row_t directed_rows[] = '{
        '{OP_FREE,    27'd0,         32'd0,          1, ST_OK,      32'd0},
        '{OP_FREE,    27'd0,         32'd5,          1, ST_NOBLOCK, 32'd0},
        '{OP_ALLOC,   27'd0,         32'd0,          1, ST_SIZE,    32'd0},
        '{OP_ALLOC,   27'd100000001, 32'd0,          1, ST_SIZE,    32'd0},
        '{OP_REALLOC, 27'd0,         32'd0,          1, ST_SIZE,    32'd0},
        '{2'd3,       27'h7FFFFFF,   32'hFFFFFFFF,   1, ST_OK,      32'd0},
        '{OP_ALLOC,   27'd100,       32'd0,          1, ST_OK,      32'd32},
        '{OP_ALLOC,   27'd1,         32'd0,          1, ST_OK,      32'd164},
        '{OP_REALLOC, 27'd50,        32'd32,         1, ST_OK,      32'd32},
        '{OP_REALLOC, 27'd200,       32'd32,         0, ST_OK,      32'd0},
        '{OP_FREE,    27'd0,         32'd164,        1, ST_OK,      32'd0},
        '{OP_FREE,    27'd0,         32'd164,        1, ST_OK,      32'd0},
        '{OP_ALLOC,   27'd80,        32'd0,          0, ST_OK,      32'd0},
        '{OP_REALLOC, 27'd10,        32'd0,          0, ST_OK,      32'd0},
        '{OP_REALLOC, 27'd10,        32'd7,          1, ST_NOBLOCK, 32'd0},
        '{OP_FREE,    27'd0,         32'hFFFFFFFF,   1, ST_NOBLOCK, 32'd0},
        '{OP_ALLOC,   27'd100000000, 32'd0,          0, ST_OK,      32'd0},
        '{OP_REALLOC, 27'h7FFFFFF,   32'd0,          1, ST_SIZE,    32'd0},
        '{OP_FREE,    27'd0,         32'h80000000,   1, ST_NOBLOCK, 32'd0}
    };

    initial
    begin
        req_t r;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_MAX_REQUEST;
        cfg_data = '0;
        error_count = 0;
        idle_cycles = 0;
        heap_max_request = MAX_REQUEST_RESET;
        heap_capacity = HEAP_CAPACITY_RESET;
        blk_count = 0;
        free_cnt = 0;
        free_byte_sum = '0;
        total_byte_sum = '0;
        heap_break = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            r.opcode = directed_rows[i].op;
            r.request_size = directed_rows[i].size;
            r.block_address = directed_rows[i].addr;
            send_item(r, directed_rows[i].typed, directed_rows[i].st,
                      directed_rows[i].res);
        end

        // max_request extremes, then a zero heap capacity
        write_reg(CFG_MAX_REQUEST, 32'd1);
        r = '{OP_ALLOC, 27'd2, 32'd0};
        send_item(r, 1, ST_SIZE, 32'd0);
        r = '{OP_ALLOC, 27'd1, 32'd0};
        send_item(r);
        write_reg(CFG_MAX_REQUEST, 32'h07FF_FFFF);
        r = '{OP_ALLOC, 27'h7FFFFFF, 32'd0};
        send_item(r);
        write_reg(CFG_HEAP_CAPACITY, 32'd0);
        r = '{OP_ALLOC, 27'h7FFFFFF, 32'd0};
        send_item(r, 1, ST_SPACE, 32'd0);

        // random phases, each with its own register setting
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(CFG_MAX_REQUEST, 32'(MAX_REQUEST_RESET));
                    write_reg(CFG_HEAP_CAPACITY, 32'hFFFF_FFFF);
                end
                1: write_reg(CFG_HEAP_CAPACITY, heap_break + 32'd3000);
                2: write_reg(CFG_MAX_REQUEST, 32'($urandom_range(1, 300)));
                3: write_reg(CFG_HEAP_CAPACITY, 32'd0);
                4:
                begin
                    write_reg(CFG_MAX_REQUEST, 32'h07FF_FFFF);
                    write_reg(CFG_HEAP_CAPACITY, heap_break + 32'($urandom_range(0, 1 << 20)));
                end
                default:
                begin
                    write_reg(CFG_MAX_REQUEST, 32'd4096);
                    write_reg(CFG_HEAP_CAPACITY, 32'hFFFF_FFFF);
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(random_item());
        end

        for (int n = 0; n < 12; n++)
            send_item(random_item());

        wait_idle();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("first_fit_block_allocator verification clean");
        else
            $display("first_fit_block_allocator verification failed");
        $finish;
    end
endmodule
`default_nettype wire
